[design/iff_pkg.sv]
`default_nettype none

package iff_pkg;

    localparam int MAX_FIELD = 32;
    localparam int FLD_W     = 6;
    localparam int VAL_W     = 32;
    localparam int NDIG      = 10;
    localparam int BCD_W     = 4 * NDIG;
    localparam int ND_W      = 4;

    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic             kind;
        logic [VAL_W-1:0] value;
        logic [FLD_W-1:0] width;
        logic             has_precision;
        logic [FLD_W-1:0] precision;
        logic             zero_fill;
    } in_item_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic       empty_res;
    } out_item_t;

    // Per-item settings kept while the digits are being produced.
    typedef struct packed {
        logic             neg;
        logic             zfill;
        logic             drop;
        logic             hasp;
        logic [FLD_W-1:0] wid;
        logic [FLD_W-1:0] prec;
    } job_t;

    // Digits left-aligned so the most significant one sits in the top nibble.
    typedef struct packed {
        logic [BCD_W-1:0] digits;
        logic [ND_W-1:0]  nd;
    } conv_res_t;

    function automatic logic [FLD_W-1:0] sat_field(input logic [FLD_W-1:0] v);
        logic [FLD_W-1:0] m;
        m = FLD_W'(MAX_FIELD);
        return (v > m) ? m : v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] c;
        case (d)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'ha: c = 8'h61;
            4'hb: c = 8'h62;
            4'hc: c = 8'h63;
            4'hd: c = 8'h64;
            4'he: c = 8'h65;
            default: c = 8'h66;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[design/iff_conv.sv]
`default_nettype none

module iff_conv (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire logic                hex,
    input  wire logic [31:0]         mag,
    output logic                     done,
    output iff_pkg::conv_res_t       res
);
    import iff_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DAB  = 2'd1;
    localparam logic [1:0] ST_NORM = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [VAL_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [ND_W-1:0]  nd_reg, nd_next;
    logic [BCD_W-1:0] adj;
    logic             norm_shift;

    // Add-3 correction on every BCD digit before the next shift.
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                         : bcd_reg[4*i +: 4];
        end
    end

    assign norm_shift = (nd_reg > ND_W'(1)) && (bcd_reg[BCD_W-1 -: 4] == 4'd0);

    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        nd_next    = nd_reg;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    nd_next  = ND_W'(NDIG);
                    bin_next = mag;
                    cnt_next = 5'(VAL_W - 1);
                    if (hex)
                    begin
                        bcd_next   = BCD_W'(mag);
                        state_next = ST_NORM;
                    end
                    else
                    begin
                        bcd_next   = '0;
                        state_next = ST_DAB;
                    end
                end
            end
            ST_DAB:
            begin
                bcd_next = {adj[BCD_W-2:0], bin_reg[VAL_W-1]};
                bin_next = {bin_reg[VAL_W-2:0], 1'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (norm_shift)
                begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    nd_next  = nd_reg - ND_W'(1);
                end
                else
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        nd_reg  <= nd_next;
    end

    assign res.digits = bcd_reg;
    assign res.nd     = nd_reg;

endmodule

`default_nettype wire

[design/iff_emit.sv]
`default_nettype none

module iff_emit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire iff_pkg::job_t       job,
    input  wire iff_pkg::conv_res_t  conv,
    output logic                     done,
    output logic                     strobe,
    output iff_pkg::out_item_t       result
);
    import iff_pkg::*;

    logic             active_reg, active_next;
    logic             empty_reg;
    logic             neg_reg;
    logic             zfill_reg;
    logic [FLD_W-1:0] k_reg, k_next;
    logic [FLD_W-1:0] total_reg;
    logic [FLD_W-1:0] pad_reg;
    logic [FLD_W-1:0] dstart_reg;
    logic [BCD_W-1:0] dig_reg, dig_next;
    logic             strobe_reg, strobe_next;
    out_item_t        res_reg, res_next;

    logic [FLD_W-1:0] nd_eff;
    logic [FLD_W-1:0] pd;
    logic [FLD_W-1:0] body;
    logic [FLD_W-1:0] pad;
    logic [FLD_W-1:0] total;
    logic             is_last;
    logic             is_digit;
    logic [7:0]       ch;

    // Field layout, worked out once when the digits arrive.
    always_comb
    begin
        nd_eff = job.drop ? '0 : FLD_W'(conv.nd);
        pd     = (job.hasp && (job.prec > nd_eff)) ? job.prec : nd_eff;
        body   = pd + FLD_W'(job.neg);
        pad    = (job.wid > body) ? job.wid - body : '0;
        total  = body + pad;
    end

    assign is_last = empty_reg || (k_reg == total_reg - FLD_W'(1));
    assign done    = active_reg && is_last;

    always_comb
    begin
        is_digit = 1'b0;
        if (zfill_reg)
        begin
            if (neg_reg && (k_reg == '0))
                ch = CH_MINUS;
            else if (k_reg < dstart_reg)
                ch = CH_ZERO;
            else
            begin
                ch       = hex_char(dig_reg[BCD_W-1 -: 4]);
                is_digit = 1'b1;
            end
        end
        else
        begin
            if (k_reg < pad_reg)
                ch = CH_SPACE;
            else if (neg_reg && (k_reg == pad_reg))
                ch = CH_MINUS;
            else if (k_reg < dstart_reg)
                ch = CH_ZERO;
            else
            begin
                ch       = hex_char(dig_reg[BCD_W-1 -: 4]);
                is_digit = 1'b1;
            end
        end
    end

    always_comb
    begin
        active_next = active_reg;
        k_next      = k_reg;
        dig_next    = dig_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        if (start)
        begin
            active_next = 1'b1;
            k_next      = '0;
            dig_next    = conv.digits;
        end
        else if (active_reg)
        begin
            strobe_next        = 1'b1;
            res_next.last      = is_last;
            res_next.empty_res = empty_reg;
            res_next.character = empty_reg ? CH_NUL : ch;
            k_next             = k_reg + FLD_W'(1);
            if (is_digit)
                dig_next = {dig_reg[BCD_W-5:0], 4'd0};
            if (is_last)
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        dig_reg <= dig_next;
        res_reg <= res_next;
        if (start)
        begin
            empty_reg  <= (total == '0);
            neg_reg    <= job.neg;
            zfill_reg  <= job.zfill;
            total_reg  <= total;
            pad_reg    <= pad;
            dstart_reg <= total - nd_eff;
        end
    end

    assign strobe = strobe_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

[design/integer_field_formatter_unit.sv]
`default_nettype none

// A hex item goes straight to the leading-zero strip (one digit per cycle); a decimal item
// first passes the bit-serial BCD converter (one bit per cycle) and then the strip.
// Characters follow one per cycle. Busy falls as the last character of an item is put out,
// and a new item is taken only while busy is low.
// Reset: rst_n clears all control state asynchronously; the unit comes up idle.
// The receiver cannot stall: strobe marks each character on result for exactly one cycle.
module integer_field_formatter_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire iff_pkg::in_item_t   cmd,
    output logic                     strobe,
    output iff_pkg::out_item_t       result
);
    import iff_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    job_t             job_reg, job_next;
    logic             accept;
    logic             neg;
    logic [VAL_W-1:0] mag;
    logic             conv_done;
    conv_res_t        conv_res;
    logic             emit_done;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign neg    = !cmd.kind && cmd.value[VAL_W-1];
    assign mag    = neg ? VAL_W'(0) - cmd.value : cmd.value;

    always_comb
    begin
        job_next = job_reg;
        if (accept)
        begin
            job_next.neg   = neg;
            job_next.hasp  = cmd.has_precision;
            job_next.zfill = cmd.zero_fill && !cmd.has_precision;
            job_next.wid   = sat_field(cmd.width);
            job_next.prec  = sat_field(cmd.precision);
            // A zero value with an explicit precision of zero prints no digits.
            job_next.drop  = (cmd.value == '0) && cmd.has_precision
                             && (cmd.precision == '0);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (conv_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    iff_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .hex   (cmd.kind),
        .mag   (mag),
        .done  (conv_done),
        .res   (conv_res)
    );

    iff_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_done),
        .job    (job_reg),
        .conv   (conv_res),
        .done   (emit_done),
        .strobe (strobe),
        .result (result)
    );

`ifndef NO_ASSERTIONS
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.empty_res |-> result.last)
        else $error("empty result not marked last");

    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result strobe without an item in progress");

    a_conv_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> (state_reg == ST_CONV))
        else $error("converter finished outside the conversion phase");

    a_last_frees_unit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_done |=> !busy)
        else $error("unit still busy after the final character");
`endif

endmodule

`default_nettype wire

[test/integer_field_formatter_unit_test.sv]
`default_nettype none

module integer_field_formatter_unit_test;
    import iff_pkg::*;

    localparam bit         KIND_DEC   = 1'b0;
    localparam bit         KIND_HEX   = 1'b1;
    localparam logic [7:0] CH_A_LOWER = 8'h61;
    localparam int         TAIL_CYCLES = 60;

    typedef struct {
        in_item_t conv;
        bit       drain;
    } queued_conv_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  cmd;
    logic      strobe;
    out_item_t result;

    queued_conv_t conversion_queue[$];
    out_item_t    expected_chars[$];

    logic took;
    int   gap_left;
    int   burst_left;
    int   conversions_total;
    int   conversions_accepted;
    int   hex_conversions;
    int   chars_checked;
    int   empty_fields;
    int   drain_pauses;
    int   errors;

    integer_field_formatter_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .strobe (strobe),
        .result (result)
    );

    always #6 clk = ~clk;

    task automatic log_error(input string msg);
        errors++;
        if (errors <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    // Builds the characters of one conversion and appends them to expected_chars.
    function automatic void format_conversion(input in_item_t c);
        logic [7:0]  field[0:2*MAX_FIELD];
        logic [7:0]  rev[0:31];
        logic [31:0] mag;
        logic [31:0] t;
        logic [31:0] base;
        int          wid;
        int          prec;
        int          digit;
        int          nd;
        int          pd;
        int          body;
        int          pad;
        int          k;
        int          i;
        bit          hasp;
        bit          zfill;
        bit          neg;

        wid   = (c.width > MAX_FIELD) ? MAX_FIELD : int'(c.width);
        prec  = (c.precision > MAX_FIELD) ? MAX_FIELD : int'(c.precision);
        hasp  = c.has_precision;
        zfill = c.zero_fill && !hasp;
        base  = (c.kind == KIND_HEX) ? 32'd16 : 32'd10;
        neg   = (c.kind == KIND_DEC) && c.value[31];
        mag   = neg ? (32'd0 - c.value) : c.value;

        nd = 0;
        if (!(mag == 0 && hasp && prec == 0))
        begin
            t = mag;
            do
            begin
                digit = int'(t % base);
                rev[nd] = (digit < 10) ? CH_ZERO + 8'(digit) : CH_A_LOWER + 8'(digit - 10);
                nd++;
                t = t / base;
            end
            while (t != 0);
        end

        pd   = (hasp && prec > nd) ? prec : nd;
        body = pd + (neg ? 1 : 0);
        pad  = (wid > body) ? wid - body : 0;

        if (body + pad == 0)
        begin
            expected_chars.push_back(out_item_t'{character: CH_NUL, last: 1'b1,
                                                 empty_res: 1'b1});
            return;
        end

        k = 0;
        // With zero fill the sign goes ahead of the fill zeros.
        if (zfill && neg)
        begin
            field[k] = CH_MINUS;
            k++;
        end
        for (i = 0; i < pad; i++)
        begin
            field[k] = zfill ? CH_ZERO : CH_SPACE;
            k++;
        end
        if (!zfill && neg)
        begin
            field[k] = CH_MINUS;
            k++;
        end
        for (i = nd; i < pd; i++)
        begin
            field[k] = CH_ZERO;
            k++;
        end
        for (i = nd - 1; i >= 0; i--)
        begin
            field[k] = rev[i];
            k++;
        end

        for (i = 0; i < k; i++)
        begin
            expected_chars.push_back(out_item_t'{character: field[i], last: (i == k - 1),
                                                 empty_res: 1'b0});
        end
    endfunction

    function automatic void queue_conversion(input bit kind, input logic [31:0] value,
                                             input logic [5:0] wid, input bit hasp,
                                             input logic [5:0] prec, input bit zfill,
                                             input bit drain);
        queued_conv_t q;
        q.conv.kind          = kind;
        q.conv.value         = value;
        q.conv.width         = wid;
        q.conv.has_precision = hasp;
        q.conv.precision     = prec;
        q.conv.zero_fill     = zfill;
        q.drain              = drain;
        conversion_queue.push_back(q);
    endfunction

    function automatic logic [5:0] random_field_size();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            return 6'($urandom_range(0, 12));
        end
        else if (sel < 9)
        begin
            return 6'($urandom_range(0, 40));
        end
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 20);
            1: v = 32'(0 - $urandom_range(1, 1000));
            2: v = $urandom;
            3:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_0001;
                    2: v = 32'h7fff_ffff;
                    3: v = 32'h8000_0000;
                    default: v = 32'hffff_ffff;
                endcase
            end
            4: v = 32'd1 << $urandom_range(0, 31);
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    // Sender: one item at a time, with a random gap before each one except during a burst.
    always @(negedge clk)
    begin : drive_conversions
        logic go;
        go = start;
        if (rst_n)
        begin
            if (start && took)
            begin
                go = 1'b0;
                if (burst_left != 0)
                begin
                    burst_left--;
                    gap_left = 0;
                end
                else
                begin
                    gap_left = $urandom_range(0, 17);
                    if ($urandom_range(0, 19) == 0)
                    begin
                        burst_left = $urandom_range(5, 25);
                    end
                end
            end
            if (!go && conversion_queue.size() != 0)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else if (!(conversion_queue[0].drain && expected_chars.size() != 0))
                begin
                    if (conversion_queue[0].drain)
                    begin
                        drain_pauses++;
                    end
                    cmd <= conversion_queue[0].conv;
                    void'(conversion_queue.pop_front());
                    go = 1'b1;
                end
            end
        end
        start <= go;
    end

    always @(posedge clk)
    begin : watch_characters
        out_item_t want;
        if (rst_n)
        begin
            took <= start && !busy;
            if (strobe)
            begin
                if (expected_chars.size() == 0)
                begin
                    log_error($sformatf("unexpected character %02h last %0b empty %0b",
                                        result.character, result.last, result.empty_res));
                end
                else
                begin
                    want = expected_chars.pop_front();
                    chars_checked++;
                    if (result.empty_res === 1'b1)
                    begin
                        empty_fields++;
                    end
                    if (result.character !== want.character || result.last !== want.last ||
                        result.empty_res !== want.empty_res)
                    begin
                        log_error($sformatf(
                            "character mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                            want.character, want.last, want.empty_res,
                            result.character, result.last, result.empty_res));
                    end
                end
            end
            if (start && !busy)
            begin
                format_conversion(cmd);
                conversions_accepted++;
                if (cmd.kind == KIND_HEX)
                begin
                    hex_conversions++;
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int n;
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        took       = 1'b0;
        gap_left   = 0;
        burst_left = 0;

        // Directed conversions.
        queue_conversion(KIND_DEC, 32'd0,          6'd0,  1'b0, 6'd0,  1'b0, 1'b0);
        queue_conversion(KIND_DEC, 32'd0,          6'd0,  1'b1, 6'd0,  1'b0, 1'b0);
        queue_conversion(KIND_DEC, 32'd0,          6'd5,  1'b1, 6'd0,  1'b1, 1'b0);
        queue_conversion(KIND_HEX, 32'd0,          6'd0,  1'b1, 6'd0,  1'b0, 1'b0);
        queue_conversion(KIND_HEX, 32'd0,          6'd0,  1'b0, 6'd0,  1'b0, 1'b0);
        queue_conversion(KIND_DEC, 32'h8000_0000,  6'd0,  1'b0, 6'd0,  1'b0, 1'b0);
        queue_conversion(KIND_DEC, 32'h8000_0000,  6'd20, 1'b0, 6'd0,  1'b1, 1'b0);
        queue_conversion(KIND_DEC, 32'hffff_ffff,  6'd63, 1'b0, 6'd0,  1'b1, 1'b0);
        queue_conversion(KIND_DEC, 32'hffff_fffb,  6'd0,  1'b1, 6'd63, 1'b0, 1'b0);
        queue_conversion(KIND_HEX, 32'hffff_ffff,  6'd0,  1'b0, 6'd0,  1'b0, 1'b0);
        queue_conversion(KIND_HEX, 32'hffff_ffff,  6'd63, 1'b1, 6'd63, 1'b1, 1'b0);
        queue_conversion(KIND_DEC, 32'h7fff_ffff,  6'd0,  1'b0, 6'd0,  1'b0, 1'b0);
        queue_conversion(KIND_HEX, 32'hdead_beef,  6'd12, 1'b0, 6'd0,  1'b1, 1'b0);
        queue_conversion(KIND_DEC, 32'hffff_ffd6,  6'd8,  1'b0, 6'd0,  1'b0, 1'b0);
        queue_conversion(KIND_DEC, 32'd42,         6'd8,  1'b0, 6'd0,  1'b1, 1'b0);
        queue_conversion(KIND_DEC, 32'd123,        6'd10, 1'b1, 6'd6,  1'b1, 1'b0);
        queue_conversion(KIND_HEX, 32'd1,          6'd1,  1'b1, 6'd1,  1'b0, 1'b0);
        queue_conversion(KIND_DEC, 32'hffff_fff9,  6'd0,  1'b1, 6'd0,  1'b0, 1'b0);
        queue_conversion(KIND_HEX, 32'h0000_0abc,  6'd33, 1'b0, 6'd0,  1'b0, 1'b0);
        queue_conversion(KIND_DEC, 32'd0,          6'd4,  1'b0, 6'd0,  1'b1, 1'b0);
        queue_conversion(KIND_DEC, 32'hffff_ffff,  6'd32, 1'b1, 6'd32, 1'b0, 1'b0);
        queue_conversion(KIND_HEX, 32'h0123_4567,  6'd40, 1'b1, 6'd33, 1'b1, 1'b0);

        // Random conversions; the first one waits for the directed part to drain.
        for (n = 0; n < 420; n++)
        begin
            queue_conversion($urandom_range(0, 1), random_value(), random_field_size(),
                             $urandom_range(0, 1), random_field_size(),
                             $urandom_range(0, 1), (n == 0) || ($urandom_range(0, 59) == 0));
        end
        conversions_total = conversion_queue.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
        begin
            @(negedge clk);
        end
        while (conversions_accepted != conversions_total || expected_chars.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (expected_chars.size() != 0)
        begin
            log_error($sformatf("%0d expected characters never arrived",
                                expected_chars.size()));
        end

        $display("Formatted %0d conversions (%0d hex, %0d decimal), %0d characters checked.",
                 conversions_accepted, hex_conversions, conversions_accepted - hex_conversions,
                 chars_checked);
        $display("Empty fields: %0d, full drains of the sender: %0d, errors: %0d.",
                 empty_fields, drain_pauses, errors);
        if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
